>>> sv/omnm_pkg.sv
// ----------------------------------------------------------------------------
// omnm_pkg
// Shared types, constants and helpers of the object map nearest merge block.
// ----------------------------------------------------------------------------
package omnm_pkg;

	localparam int COORD_W     = 20;
	localparam int EXT_W       = 16;
	localparam int CONF_W      = 16;
	localparam int CLASS_W     = 4;
	localparam int ID_W        = 7;
	localparam int RADIUS_W    = 10;
	localparam int RADIUS2_W   = 2 * RADIUS_W;
	localparam int SQ_W        = 2 * COORD_W;
	localparam int DIST_W      = SQ_W + 2;
	localparam int REG_W       = 60;
	localparam int APB_DATA_W  = 64;
	localparam int APB_ADDR_W  = 4;
	localparam int CLASS_COUNT = 12;

	localparam logic [REG_W-1:0] RADIUS_LOW_RESET  = 60'd68214345895076440;
	localparam logic [REG_W-1:0] RADIUS_HIGH_RESET = 60'd676090344794317400;

	typedef enum logic [1:0] {
		ACT_INSERT = 2'd0,
		ACT_MERGE  = 2'd1,
		ACT_IGNORE = 2'd2,
		ACT_FULL   = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_DECIDE,
		ST_MERGE,
		ST_DONE
	} state_t;

	typedef logic signed [COORD_W-1:0] coord_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
		coord_t z;
	} centroid_t;

	typedef struct packed {
		logic [CLASS_W-1:0] class_code;
		coord_t             centroid_x;
		coord_t             centroid_y;
		coord_t             centroid_z;
		logic [EXT_W-1:0]   extent_x;
		logic [EXT_W-1:0]   extent_y;
		logic [EXT_W-1:0]   extent_z;
		logic [CONF_W-1:0]  confidence;
	} det_t;

	typedef struct packed {
		logic [CLASS_W-1:0] class_code;
		centroid_t          centroid;
		logic [EXT_W-1:0]   extent_x;
		logic [EXT_W-1:0]   extent_y;
		logic [EXT_W-1:0]   extent_z;
		logic [CONF_W-1:0]  confidence;
	} entry_t;

	typedef struct packed {
		action_t         action;
		logic [ID_W-1:0] entry_id;
	} res_t;

	// Magnitude of a coordinate difference; always below 2^COORD_W
	function automatic logic [COORD_W-1:0] abs_diff(coord_t a, coord_t b);
		logic [COORD_W:0] d;
		d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
		if (d[COORD_W]) begin
			d = -d;
		end
		return d[COORD_W-1:0];
	endfunction

	// Floor average of two signed coordinates
	function automatic coord_t avg_coord(coord_t a, coord_t b);
		logic [COORD_W:0] s;
		s = {a[COORD_W-1], a} + {b[COORD_W-1], b};
		return s[COORD_W:1];
	endfunction

	// Floor average of two unsigned 16-bit values
	function automatic logic [EXT_W-1:0] avg_u16(logic [EXT_W-1:0] a, logic [EXT_W-1:0] b);
		logic [EXT_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[EXT_W:1];
	endfunction

endpackage

>>> sv/omnm_if.sv
// ----------------------------------------------------------------------------
// omnm_if
// Valid/ready channels for detection requests and association results.
// ----------------------------------------------------------------------------
interface omnm_det_if;
	import omnm_pkg::*;

	logic valid;
	logic ready;
	det_t payload;

	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

interface omnm_res_if;
	import omnm_pkg::*;

	logic valid;
	logic ready;
	res_t payload;

	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

>>> sv/omnm_cfg.sv
// ----------------------------------------------------------------------------
// omnm_cfg
// APB register file holding the per-class match radii, with class lookup.
// ----------------------------------------------------------------------------
module omnm_cfg (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [omnm_pkg::APB_ADDR_W-1:0]     paddr,
	input  logic [omnm_pkg::APB_DATA_W-1:0]     pwdata,
	output logic [omnm_pkg::APB_DATA_W-1:0]     prdata,
	output logic                                pready,
	input  logic [omnm_pkg::CLASS_W-1:0]        class_code,
	output logic [omnm_pkg::RADIUS_W-1:0]       radius
);
	import omnm_pkg::*;

	logic [REG_W-1:0]   radius_low_q;
	logic [REG_W-1:0]   radius_high_q;
	logic [2*REG_W-1:0] radius_all;
	logic               wr_en;
	logic               sel_high;

	assign pready   = 1'b1;
	assign wr_en    = psel && penable && pwrite && pready;
	// Each register spans eight bytes; address bit 3 picks the register, bits 2:0 are unused
	assign sel_high = paddr[3];

	// Write the addressed radius register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_low_q  <= RADIUS_LOW_RESET;
			radius_high_q <= RADIUS_HIGH_RESET;
		end else if (wr_en) begin
			if (sel_high) begin
				radius_high_q <= pwdata[REG_W-1:0];
			end else begin
				radius_low_q <= pwdata[REG_W-1:0];
			end
		end
	end

	// Return the addressed register
	assign prdata = sel_high ? APB_DATA_W'(radius_high_q) : APB_DATA_W'(radius_low_q);

	// Pick the radius field of the requested class
	assign radius_all = {radius_high_q, radius_low_q};

	always_comb begin
		radius = '0;
		if (32'(class_code) < CLASS_COUNT) begin
			radius = radius_all[RADIUS_W*class_code +: RADIUS_W];
		end
	end

endmodule

>>> sv/omnm_table.sv
// ----------------------------------------------------------------------------
// omnm_table
// Object table memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module omnm_table #(
	parameter int DEPTH = 64,
	parameter int IDX_W = 6
) (
	input  logic                 clk,
	input  logic                 wr_en,
	input  logic [IDX_W-1:0]     wr_addr,
	input  omnm_pkg::entry_t     wr_data,
	input  logic                 rd_en,
	input  logic [IDX_W-1:0]     rd_addr,
	output omnm_pkg::entry_t     rd_data
);
	import omnm_pkg::*;

	entry_t mem [DEPTH];
	entry_t rd_data_q;

	// Store an entry
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Fetch an entry
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

>>> sv/omnm_dist.sv
// ----------------------------------------------------------------------------
// omnm_dist
// Pipelined squared-distance unit shared by the same-class entries of a table scan.
// ----------------------------------------------------------------------------
module omnm_dist #(
	parameter int IDX_W = 6
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic [IDX_W-1:0]              in_idx,
	input  omnm_pkg::centroid_t           det_c,
	input  omnm_pkg::centroid_t           ent_c,
	output logic                          out_valid,
	output logic [IDX_W-1:0]              out_idx,
	output logic [omnm_pkg::DIST_W-1:0]   out_dist,
	output logic                          busy
);
	import omnm_pkg::*;

	logic               v_s2, v_s3, v_s4;
	logic [IDX_W-1:0]   idx_s2, idx_s3, idx_s4;
	logic [COORD_W-1:0] ad_x_s2, ad_y_s2, ad_z_s2;
	logic [SQ_W-1:0]    sq_x_s3, sq_y_s3, sq_z_s3;
	logic [DIST_W-1:0]  dist_s4;

	// Advance stage valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s2 <= in_valid;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// Absolute differences, squares, then the sum of the three axes
	always_ff @(posedge clk) begin
		idx_s2  <= in_idx;
		ad_x_s2 <= abs_diff(det_c.x, ent_c.x);
		ad_y_s2 <= abs_diff(det_c.y, ent_c.y);
		ad_z_s2 <= abs_diff(det_c.z, ent_c.z);

		idx_s3  <= idx_s2;
		sq_x_s3 <= SQ_W'(ad_x_s2) * SQ_W'(ad_x_s2);
		sq_y_s3 <= SQ_W'(ad_y_s2) * SQ_W'(ad_y_s2);
		sq_z_s3 <= SQ_W'(ad_z_s2) * SQ_W'(ad_z_s2);

		idx_s4  <= idx_s3;
		dist_s4 <= DIST_W'(sq_x_s3) + DIST_W'(sq_y_s3) + DIST_W'(sq_z_s3);
	end

	assign out_valid = v_s4;
	assign out_idx   = idx_s4;
	assign out_dist  = dist_s4;
	assign busy      = v_s2 || v_s3 || v_s4;

endmodule

>>> sv/object_map_nearest_merge.sv
// ----------------------------------------------------------------------------
// object_map_nearest_merge
// Associates each detection with the nearest stored object of its class,
// merging it by floor averages or appending it as a new object; a full table
// drops it and an unknown class is ignored. The sequencer steps through scan,
// drain of the distance pipeline, decide (which appends) and merge write-back,
// then loads the result register; a new request is taken only back in idle.
// The scan reads one entry per cycle; the drain is shorter when the last entries
// are of another class. An empty table skips the scan; an unknown class goes to done.
// Reset clears the entry count and radii take their defaults; no clear pass.
// ----------------------------------------------------------------------------
module object_map_nearest_merge #(
	parameter int TABLE_CAPACITY = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	omnm_det_if.sink                            det,
	omnm_res_if.source                          res,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [omnm_pkg::APB_ADDR_W-1:0]     paddr,
	input  logic [omnm_pkg::APB_DATA_W-1:0]     pwdata,
	output logic [omnm_pkg::APB_DATA_W-1:0]     prdata,
	output logic                                pready
);
	import omnm_pkg::*;

	localparam int CNT_W = $clog2(TABLE_CAPACITY + 1);
	localparam int IDX_W = $clog2(TABLE_CAPACITY);

	state_t             state_q, state_d;
	det_t               det_q;
	logic [RADIUS2_W-1:0] r2_q;
	logic [CNT_W-1:0]   count_q;
	logic [IDX_W-1:0]   scan_q;
	logic               rd_v_s1;
	logic [IDX_W-1:0]   rd_idx_s1;
	logic               found_q;
	logic [IDX_W-1:0]   best_q;
	logic [DIST_W-1:0]  best_d_q;
	res_t               pend_q;
	logic               res_valid_q;
	res_t               res_q;

	logic [RADIUS_W-1:0] radius;
	logic               accept;
	logic               known_class;
	logic               last_scan;
	logic               merge_hit;
	logic               full;
	logic               out_load;
	logic               det_ready;

	logic               mem_we;
	logic [IDX_W-1:0]   mem_waddr;
	entry_t             mem_wdata;
	logic               mem_re;
	logic [IDX_W-1:0]   mem_raddr;
	entry_t             mem_rdata;
	entry_t             new_entry;
	entry_t             merged_entry;

	logic               dist_in_v;
	logic               dist_vld;
	logic [IDX_W-1:0]   dist_idx;
	logic [DIST_W-1:0]  dist_d;
	logic               dist_busy;
	centroid_t          det_c;

	omnm_cfg u_cfg (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.class_code (det.payload.class_code),
		.radius     (radius)
	);

	omnm_table #(
		.DEPTH (TABLE_CAPACITY),
		.IDX_W (IDX_W)
	) u_table (
		.clk     (clk),
		.wr_en   (mem_we),
		.wr_addr (mem_waddr),
		.wr_data (mem_wdata),
		.rd_en   (mem_re),
		.rd_addr (mem_raddr),
		.rd_data (mem_rdata)
	);

	assign det_c = '{x: det_q.centroid_x, y: det_q.centroid_y, z: det_q.centroid_z};

	// Only entries of the request's class enter the distance unit
	assign dist_in_v = rd_v_s1 && (mem_rdata.class_code == det_q.class_code);

	omnm_dist #(
		.IDX_W (IDX_W)
	) u_dist (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (dist_in_v),
		.in_idx    (rd_idx_s1),
		.det_c     (det_c),
		.ent_c     (mem_rdata.centroid),
		.out_valid (dist_vld),
		.out_idx   (dist_idx),
		.out_dist  (dist_d),
		.busy      (dist_busy)
	);

	// Decode conditions
	assign accept      = det.valid && det_ready;
	assign known_class = 32'(det.payload.class_code) < CLASS_COUNT;
	assign last_scan   = (CNT_W'(scan_q) + CNT_W'(1)) == count_q;
	assign merge_hit   = found_q && (best_d_q < DIST_W'(r2_q));
	assign full        = count_q == CNT_W'(TABLE_CAPACITY);
	assign out_load    = (state_q == ST_DONE) && (!res_valid_q || res.ready);

	// Build the appended and the merged entry
	always_comb begin
		new_entry.class_code = det_q.class_code;
		new_entry.centroid   = det_c;
		new_entry.extent_x   = det_q.extent_x;
		new_entry.extent_y   = det_q.extent_y;
		new_entry.extent_z   = det_q.extent_z;
		new_entry.confidence = det_q.confidence;

		merged_entry.class_code = mem_rdata.class_code;
		merged_entry.centroid.x = avg_coord(mem_rdata.centroid.x, det_q.centroid_x);
		merged_entry.centroid.y = avg_coord(mem_rdata.centroid.y, det_q.centroid_y);
		merged_entry.centroid.z = avg_coord(mem_rdata.centroid.z, det_q.centroid_z);
		merged_entry.extent_x   = avg_u16(mem_rdata.extent_x, det_q.extent_x);
		merged_entry.extent_y   = avg_u16(mem_rdata.extent_y, det_q.extent_y);
		merged_entry.extent_z   = avg_u16(mem_rdata.extent_z, det_q.extent_z);
		merged_entry.confidence = avg_u16(mem_rdata.confidence, det_q.confidence);
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (det.valid) begin
					if (!known_class) begin
						state_d = ST_DONE;
					end else if (count_q == '0) begin
						state_d = ST_DECIDE;
					end else begin
						state_d = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				if (last_scan) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!rd_v_s1 && !dist_busy) begin
					state_d = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				state_d = merge_hit ? ST_MERGE : ST_DONE;
			end
			ST_MERGE: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Outputs of the sequencer
	always_comb begin
		det_ready = 1'b0;
		mem_re    = 1'b0;
		mem_raddr = best_q;
		mem_we    = 1'b0;
		mem_waddr = count_q[IDX_W-1:0];
		mem_wdata = new_entry;
		case (state_q)
			ST_IDLE: begin
				det_ready = 1'b1;
			end
			ST_SCAN: begin
				mem_re    = 1'b1;
				mem_raddr = scan_q;
			end
			ST_DECIDE: begin
				// fetch the winner for merging, or append when there is room
				mem_re = merge_hit;
				mem_we = !merge_hit && !full;
			end
			ST_MERGE: begin
				mem_we    = 1'b1;
				mem_waddr = best_q;
				mem_wdata = merged_entry;
			end
			default: begin
			end
		endcase
	end

	assign det.ready = det_ready;

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			scan_q      <= '0;
			rd_v_s1     <= 1'b0;
			found_q     <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			rd_v_s1 <= (state_q == ST_SCAN);

			if (accept) begin
				scan_q  <= '0;
				found_q <= 1'b0;
			end else if (state_q == ST_SCAN) begin
				scan_q <= scan_q + IDX_W'(1);
			end

			if (dist_vld && (!found_q || dist_d < best_d_q)) begin
				found_q <= 1'b1;
			end

			if (state_q == ST_DECIDE && !merge_hit && !full) begin
				count_q <= count_q + CNT_W'(1);
			end

			if (out_load) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			det_q <= det.payload;
			r2_q  <= RADIUS2_W'(radius) * RADIUS2_W'(radius);
		end

		rd_idx_s1 <= scan_q;

		// Keep the earliest entry on equal distances
		if (dist_vld && (!found_q || dist_d < best_d_q)) begin
			best_q   <= dist_idx;
			best_d_q <= dist_d;
		end

		if (accept && !known_class) begin
			pend_q <= '{action: ACT_IGNORE, entry_id: '0};
		end else if (state_q == ST_DECIDE && !merge_hit) begin
			if (full) begin
				pend_q <= '{action: ACT_FULL, entry_id: '0};
			end else begin
				pend_q <= '{action: ACT_INSERT, entry_id: ID_W'(count_q + CNT_W'(1))};
			end
		end else if (state_q == ST_MERGE) begin
			pend_q <= '{action: ACT_MERGE, entry_id: ID_W'(CNT_W'(best_q) + CNT_W'(1))};
		end

		if (out_load) begin
			res_q <= pend_q;
		end
	end

	assign res.valid   = res_valid_q;
	assign res.payload = res_q;

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(TABLE_CAPACITY))
		else $error("entry count beyond capacity");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != $past(count_q)) |-> (count_q == $past(count_q) + CNT_W'(1)))
		else $error("entry count moved by more than one");

	a_write_state: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == ST_DECIDE || state_q == ST_MERGE))
		else $error("table written outside decide or merge");

	a_dist_state: assert property (@(posedge clk) disable iff (!arst_n)
		dist_vld |-> (state_q == ST_SCAN || state_q == ST_DRAIN))
		else $error("distance result outside a scan");

	a_merge_found: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MERGE) |-> found_q)
		else $error("merge without a candidate");

	a_res_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(state_q == ST_DONE))
		else $error("result raised outside done");
`endif

endmodule

>>> verif/tb_object_map_nearest_merge.sv
// ----------------------------------------------------------------------------
// tb_object_map_nearest_merge
// Drives detections into the object map and checks every association result
// against a mirror of the object table: nearest same-class entry, merge by
// floor averages inside the class radius, append otherwise, drop when full.
// ----------------------------------------------------------------------------
module tb_object_map_nearest_merge;
	import omnm_pkg::*;

	localparam int CAPACITY   = 64;
	localparam int IDLE_LIMIT = 5000;
	localparam int END_SETTLE = 80;
	localparam int PRINT_CAP  = 200;

	localparam logic [APB_ADDR_W-1:0] ADDR_RADIUS_LOW  = 4'd0;
	localparam logic [APB_ADDR_W-1:0] ADDR_RADIUS_HIGH = 4'd8;

	typedef enum logic [1:0] {
		RX_OPEN,
		RX_CHOPPY,
		RX_CLOGGED
	} rx_mode_t;

	// Mirror of the object table; computes the action owed for each request
	class object_table_mirror;
		entry_t           slots[$];
		int unsigned      capacity;
		logic [REG_W-1:0] radii_low;
		logic [REG_W-1:0] radii_high;
		res_t             actions_owed[$];
		int unsigned      mismatches;

		function new(int unsigned cap);
			capacity   = cap;
			radii_low  = RADIUS_LOW_RESET;
			radii_high = RADIUS_HIGH_RESET;
			mismatches = 0;
		endfunction

		// Six classes per radius register
		function logic [RADIUS_W-1:0] radius(logic [CLASS_W-1:0] cls);
			if (cls < 6) begin
				return radii_low[RADIUS_W*cls +: RADIUS_W];
			end
			return radii_high[RADIUS_W*(cls-6) +: RADIUS_W];
		endfunction

		function longint squared_gap(centroid_t a, centroid_t b);
			longint dx, dy, dz;
			dx = longint'($signed(a.x)) - longint'($signed(b.x));
			dy = longint'($signed(a.y)) - longint'($signed(b.y));
			dz = longint'($signed(a.z)) - longint'($signed(b.z));
			return dx*dx + dy*dy + dz*dz;
		endfunction

		// Floor average, rounding toward minus infinity
		function coord_t halve_coord(coord_t a, coord_t b);
			longint sum;
			sum = longint'($signed(a)) + longint'($signed(b));
			return coord_t'(sum >>> 1);
		endfunction

		function logic [EXT_W-1:0] mean_u16(logic [EXT_W-1:0] a, logic [EXT_W-1:0] b);
			return EXT_W'((int'(a) + int'(b)) / 2);
		endfunction

		function void note_detection(det_t d);
			res_t      verdict;
			centroid_t spot;
			entry_t    hit;
			int        best;
			longint    gap_sq;
			longint    best_dist;
			longint    reach;
			spot.x    = d.centroid_x;
			spot.y    = d.centroid_y;
			spot.z    = d.centroid_z;
			best      = -1;
			best_dist = 0;
			if (d.class_code >= CLASS_COUNT) begin
				verdict.action   = ACT_IGNORE;
				verdict.entry_id = '0;
			end else begin
				// strictly smaller wins, so the earliest entry keeps a tie
				foreach (slots[i]) begin
					if (slots[i].class_code == d.class_code) begin
						gap_sq = squared_gap(slots[i].centroid, spot);
						if (best < 0 || gap_sq < best_dist) begin
							best      = i;
							best_dist = gap_sq;
						end
					end
				end
				reach = longint'(radius(d.class_code)) * longint'(radius(d.class_code));
				if (best >= 0 && best_dist < reach) begin
					hit            = slots[best];
					hit.centroid.x = halve_coord(hit.centroid.x, spot.x);
					hit.centroid.y = halve_coord(hit.centroid.y, spot.y);
					hit.centroid.z = halve_coord(hit.centroid.z, spot.z);
					hit.extent_x   = mean_u16(hit.extent_x, d.extent_x);
					hit.extent_y   = mean_u16(hit.extent_y, d.extent_y);
					hit.extent_z   = mean_u16(hit.extent_z, d.extent_z);
					hit.confidence = mean_u16(hit.confidence, d.confidence);
					slots[best]    = hit;
					verdict.action   = ACT_MERGE;
					verdict.entry_id = ID_W'(best + 1);
				end else if (slots.size() >= capacity) begin
					verdict.action   = ACT_FULL;
					verdict.entry_id = '0;
				end else begin
					hit.class_code = d.class_code;
					hit.centroid   = spot;
					hit.extent_x   = d.extent_x;
					hit.extent_y   = d.extent_y;
					hit.extent_z   = d.extent_z;
					hit.confidence = d.confidence;
					slots.insert(slots.size(), hit);
					verdict.action   = ACT_INSERT;
					verdict.entry_id = ID_W'(slots.size());
				end
			end
			actions_owed.insert(actions_owed.size(), verdict);
		endfunction

		task flag_mismatch(string msg);
			mismatches++;
			if (mismatches <= PRINT_CAP) begin
				$display("MISMATCH: %s", msg);
			end
		endtask

		task check_action(res_t got);
			res_t want;
			if (actions_owed.size() == 0) begin
				flag_mismatch($sformatf("result with nothing pending: action %0d id %0d",
					got.action, got.entry_id));
				return;
			end
			want = actions_owed.pop_front();
			if (got.action !== want.action) begin
				flag_mismatch($sformatf("action got %0d want %0d (want id %0d)",
					got.action, want.action, want.entry_id));
			end
			if (got.entry_id !== want.entry_id) begin
				flag_mismatch($sformatf("entry_id got %0d want %0d (action %0d)",
					got.entry_id, want.entry_id, want.action));
			end
		endtask
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	omnm_det_if det_ch();
	omnm_res_if res_ch();

	object_table_mirror table_mirror;

	rx_mode_t    rx_mode   = RX_OPEN;
	int unsigned rx_left   = 0;
	int unsigned quiet_cycles = 0;

	object_map_nearest_merge #(
		.TABLE_CAPACITY(CAPACITY)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.det(det_ch),
		.res(res_ch),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 0;
	end

	// Stall the result side in modes of random length
	always @(posedge clk) begin
		if (rx_left == 0) begin
			rx_mode       <= rx_mode_t'($urandom_range(0, 2));
			rx_left       <= $urandom_range(20, 200);
			res_ch.ready  <= 1'b1;
		end else begin
			rx_left <= rx_left - 1;
			case (rx_mode)
				RX_OPEN: begin
					res_ch.ready <= 1'b1;
				end
				RX_CHOPPY: begin
					res_ch.ready <= 1'($urandom_range(0, 1));
				end
				default: begin
					res_ch.ready <= ($urandom_range(0, 7) == 0);
				end
			endcase
		end
	end

	// Check each accepted result
	always @(posedge clk) begin
		if (arst_n === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
			table_mirror.check_action(res_ch.payload);
		end
	end

	// Abort when nothing moves for too long
	always @(posedge clk) begin
		if ((det_ch.valid === 1'b1 && det_ch.ready === 1'b1) ||
		    (res_ch.valid === 1'b1 && res_ch.ready === 1'b1)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	function automatic det_t make_det(int cls, int x, int y, int z,
	                                  int ex, int ey, int ez, int conf);
		det_t d;
		d.class_code = CLASS_W'(cls);
		d.centroid_x = coord_t'(x);
		d.centroid_y = coord_t'(y);
		d.centroid_z = coord_t'(z);
		d.extent_x   = EXT_W'(ex);
		d.extent_y   = EXT_W'(ey);
		d.extent_z   = EXT_W'(ez);
		d.confidence = CONF_W'(conf);
		return d;
	endfunction

	function automatic coord_t clamp_coord(int v);
		if (v > 524287) begin
			return coord_t'(524287);
		end
		if (v < -524288) begin
			return coord_t'(-524288);
		end
		return coord_t'(v);
	endfunction

	function automatic int jitter(int span);
		return int'($urandom_range(0, 2 * span)) - span;
	endfunction

	// Mostly re-observations of stored objects, some new objects, a little noise
	function automatic det_t random_detection(int new_pct);
		det_t          d;
		entry_t        anchor;
		int            roll;
		int            span;
		int unsigned   pick;
		logic [RADIUS_W-1:0] rad;
		roll         = $urandom_range(0, 99);
		d.class_code = CLASS_W'($urandom_range(0, CLASS_COUNT - 1));
		d.centroid_x = coord_t'($urandom);
		d.centroid_y = coord_t'($urandom);
		d.centroid_z = coord_t'($urandom);
		d.extent_x   = EXT_W'($urandom);
		d.extent_y   = EXT_W'($urandom);
		d.extent_z   = EXT_W'($urandom);
		d.confidence = CONF_W'($urandom);
		if (roll < 3) begin
			d.class_code = CLASS_W'($urandom_range(CLASS_COUNT, 15));
		end else if (roll >= 3 + new_pct && table_mirror.slots.size() > 0) begin
			pick   = $urandom_range(0, table_mirror.slots.size() - 1);
			anchor = table_mirror.slots[pick];
			rad    = table_mirror.radius(anchor.class_code);
			if (roll % 8 == 0) begin
				span = 0;
			end else if (roll % 8 == 1) begin
				span = int'(rad) + int'(rad) / 2;
			end else if (roll % 4 == 2) begin
				span = int'(rad);
			end else begin
				span = int'(rad) / 2;
			end
			d.class_code = anchor.class_code;
			d.centroid_x = clamp_coord(int'($signed(anchor.centroid.x)) + jitter(span));
			d.centroid_y = clamp_coord(int'($signed(anchor.centroid.y)) + jitter(span));
			d.centroid_z = clamp_coord(int'($signed(anchor.centroid.z)) + jitter(span));
		end
		return d;
	endfunction

	// Hold the request until accepted, then record it
	task automatic send_request(input det_t item);
		det_ch.valid   <= 1'b1;
		det_ch.payload <= item;
		do @(posedge clk); while (det_ch.ready !== 1'b1);
		table_mirror.note_detection(item);
	endtask

	task automatic pause_sender(input int cycles);
		if (cycles > 0) begin
			det_ch.valid <= 1'b0;
			repeat (cycles) @(posedge clk);
		end
	endtask

	// Drop valid and wait until every owed result is back
	task automatic drain_requests();
		det_ch.valid <= 1'b0;
		while (table_mirror.actions_owed.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(input logic [APB_ADDR_W-1:0] addr,
	                         input logic [APB_DATA_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		if (addr == ADDR_RADIUS_LOW) begin
			table_mirror.radii_low = value[REG_W-1:0];
		end else if (addr == ADDR_RADIUS_HIGH) begin
			table_mirror.radii_high = value[REG_W-1:0];
		end
	endtask

	task automatic check_register(input logic [APB_ADDR_W-1:0] addr,
	                              input logic [REG_W-1:0] want);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= addr;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		if (prdata !== {{(APB_DATA_W-REG_W){1'b0}}, want}) begin
			table_mirror.flag_mismatch($sformatf("register at %0d reads %h, want %h",
				addr, prdata, want));
		end
	endtask

	task automatic apb_idle();
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// Reprogram both radius registers with the block drained
	task automatic set_radii(input logic [APB_DATA_W-1:0] low_word,
	                         input logic [APB_DATA_W-1:0] high_word);
		drain_requests();
		write_reg(ADDR_RADIUS_LOW, low_word);
		write_reg(ADDR_RADIUS_HIGH, high_word);
		check_register(ADDR_RADIUS_LOW, table_mirror.radii_low);
		check_register(ADDR_RADIUS_HIGH, table_mirror.radii_high);
		apb_idle();
	endtask

	// Random bursts of requests with random gaps between them
	task automatic run_traffic(input int count, input int new_pct);
		det_t item;
		int   done;
		int   burst;
		int   gap;
		done = 0;
		while (done < count) begin
			burst = $urandom_range(1, 12);
			repeat (burst) begin
				item = random_detection(new_pct);
				send_request(item);
				if (item.class_code < CLASS_COUNT) begin
					done++;
				end
			end
			case ($urandom_range(0, 9))
				0:       gap = 0;
				1, 2:    gap = $urandom_range(20, 90);
				default: gap = $urandom_range(1, 6);
			endcase
			if ($urandom_range(0, 49) == 0) begin
				drain_requests();
			end else begin
				pause_sender(gap);
			end
		end
	endtask

	initial begin
		table_mirror = new(CAPACITY);
		arst_n         <= 1'b0;
		det_ch.valid   <= 1'b0;
		det_ch.payload <= '0;
		psel           <= 1'b0;
		penable        <= 1'b0;
		pwrite         <= 1'b0;
		paddr          <= '0;
		pwdata         <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// reset values of the radius table
		check_register(ADDR_RADIUS_LOW, table_mirror.radii_low);
		check_register(ADDR_RADIUS_HIGH, table_mirror.radii_high);
		apb_idle();

		// unknown classes on an empty table
		send_request(make_det(12, 0, 0, 0, 0, 0, 0, 0));
		send_request(make_det(15, 524287, -524288, 524287, 65535, 0, 65535, 65535));
		// first entry, then another class goes in beside it
		send_request(make_det(0, 0, 0, 0, 0, 0, 0, 0));
		send_request(make_det(1, -524288, -524288, -524288, 65535, 65535, 65535, 65535));
		// merge at the negative corner, odd sums floor downward
		send_request(make_det(1, -524187, -524187, -524187, 1, 2, 3, 1));
		// distance equal to radius squared appends, one step inside merges
		send_request(make_det(0, 600, 0, 0, 100, 100, 100, 100));
		send_request(make_det(0, -599, 0, 0, 7, 7, 7, 7));
		// positive corner, then an exact hit on it
		send_request(make_det(2, 524287, 524287, 524287, 65535, 65535, 65535, 65535));
		send_request(make_det(2, 524287, 524287, 524287, 0, 0, 0, 0));
		send_request(make_det(11, 1000, -1000, 1000, 40, 50, 60, 32768));
		send_request(make_det(5, -3, 77, 123456, 1, 65534, 300, 12345));

		// widest radii; bits above the register width are dropped
		set_radii('1, '1);
		// equal distances: the earlier entry takes the merge
		send_request(make_det(3, -700, 0, 0, 10, 10, 10, 10));
		send_request(make_det(3, 700, 0, 0, 20, 20, 20, 20));
		send_request(make_det(3, 0, 0, 0, 31, 31, 31, 31));
		// opposite corners of one class: full-range distance
		send_request(make_det(4, 524287, 524287, 524287, 9, 9, 9, 9));
		send_request(make_det(4, -524288, -524288, -524288, 9, 9, 9, 9));

		// zero radii: even an exact hit appends
		set_radii('0, '0);
		send_request(make_det(0, -300, 0, 0, 3, 3, 3, 3));
		send_request(make_det(13, 1, 2, 3, 4, 5, 6, 7));
		send_request(make_det(2, 524287, 524287, 524287, 1, 1, 1, 1));

		// random traffic under several radius settings
		set_radii({$urandom, $urandom}, {$urandom, $urandom});
		run_traffic(450, 5);
		set_radii('1, '1);
		run_traffic(350, 5);
		set_radii({$urandom, $urandom} & ~64'(10'h3FF),
			{$urandom, $urandom} | (64'(10'h3FF) << 50));
		run_traffic(400, 6);
		// heavy on new objects so the table fills and drops show up
		set_radii({$urandom, $urandom}, {$urandom, $urandom});
		run_traffic(400, 25);

		drain_requests();
		repeat (END_SETTLE) @(posedge clk);
		if (table_mirror.mismatches == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
